### rtl/core/fat12cw_pkg.sv
// Package for the FAT12 cluster chain walker core.
// Holds opcodes, status codes, register indexes, table sizes and the address helpers.
// Depends on nothing; the core refers to it by scoped names.
package fat12cw_pkg;

	localparam int TABLE_BYTES = 8192;
	localparam int BANK_DEPTH  = TABLE_BYTES / 2;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_START   = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;
	localparam logic [1:0] OP_NOP     = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_CHAIN  = 2'd1;
	localparam logic [1:0] ST_BAD_START = 2'd2;

	localparam logic [2:0] CFG_RESERVED    = 3'd0;
	localparam logic [2:0] CFG_TABLE_SECT  = 3'd1;
	localparam logic [2:0] CFG_COPIES      = 3'd2;
	localparam logic [2:0] CFG_ROOT_ENTRY  = 3'd3;
	localparam logic [2:0] CFG_SECT_LOG2   = 3'd4;
	localparam logic [2:0] CFG_SECT_PER_CL = 3'd5;

	localparam logic [11:0] END_MARK      = 12'hFF8;
	localparam logic [11:0] FIRST_CLUSTER = 12'd2;

	typedef logic [23:0] sector_t;

	function automatic sector_t root_end(input logic [15:0] rsv, input logic [15:0] spt,
		input logic [2:0] copies, input logic [15:0] entries, input logic [3:0] s);
		logic [20:0] bytes;
		logic [20:0] mask;
		logic [20:0] dir;
		logic [18:0] fat;
		bytes = {entries, 5'b0};
		mask  = (21'd1 << s) - 21'd1;
		dir   = (bytes >> s) + {20'b0, |(bytes & mask)};
		fat   = {16'b0, copies} * {3'b0, spt};
		return {8'b0, rsv} + {5'b0, fat} + {3'b0, dir};
	endfunction

	function automatic logic [12:0] entry_addr(input logic [11:0] cl);
		return {1'b0, cl} + {2'b0, cl[11:1]};
	endfunction

endpackage

### rtl/core/fat12_cluster_chain_walker_core.sv
// Top level of the FAT12 cluster chain walker: table memory, chain state and result register.
// Depends on fat12cw_pkg for codes, sizes and the address helpers.
// Configuration writes arrive on their own valid/ready channel.

// A command beat is taken when start is high and busy is low, and every beat gives exactly
// one result, shown for one cycle with done high; the receiver cannot stall it. Whatever the
// opcode, the beat is registered at the edge that takes it, and done and the result register
// load at the next one. A start or advance that walks the chain reads its entry from the even
// and odd byte banks, which have registered reads, at the edge that takes the beat, then
// decodes it and computes the sector address in the following cycle. Busy stays high for
// that one cycle, since the next step starts from the cluster it finds, and no beat of any
// kind is taken while busy is high. Table writes, no-ops and rejected commands leave busy
// low and can follow one another in every cycle.
module fat12_cluster_chain_walker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [12:0] table_byte_addr,
	input  logic [7:0]  table_byte,
	input  logic [11:0] start_cluster,
	output logic        done,
	output logic [1:0]  status,
	output logic [11:0] cluster,
	output logic [23:0] sector_addr,
	output logic [11:0] next_cluster,
	output logic        chain_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = fat12cw_pkg::BANK_AW;

	logic [15:0] reserved_q;
	logic [15:0] table_sect_q;
	logic [2:0]  copies_q;
	logic [15:0] root_entry_q;
	logic [3:0]  sect_log2_q;
	logic [7:0]  sect_per_cl_q;
	fat12cw_pkg::sector_t root_end_q;

	logic [11:0] current_cluster_q;
	logic        chain_active_q;

	logic [7:0] mem_even [fat12cw_pkg::BANK_DEPTH];
	logic [7:0] mem_odd  [fat12cw_pkg::BANK_DEPTH];

	logic        acc;
	logic        step_now;
	logic [11:0] cl_now;
	logic [12:0] idx_now;
	logic [AW-1:0] even_addr;
	logic [AW-1:0] odd_addr;
	logic [1:0]  status_now;

	logic        valid_s1;
	logic        step_s1;
	logic [1:0]  status_s1;
	logic [11:0] cl_s1;
	logic        swap_s1;
	logic [7:0]  rd_even_s1;
	logic [7:0]  rd_odd_s1;

	logic [15:0] word;
	logic [11:0] nxt;
	logic        is_end;
	fat12cw_pkg::sector_t sector;

	logic        done_q;
	logic [1:0]  status_q;
	logic [11:0] cluster_q;
	logic [23:0] sector_q;
	logic [11:0] next_q;
	logic        end_q;

	assign cfg_ready = 1'b1;
	assign busy      = step_s1;
	assign acc       = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q    <= 16'd1;
			table_sect_q  <= 16'd9;
			copies_q      <= 3'd2;
			root_entry_q  <= 16'd224;
			sect_log2_q   <= 4'd9;
			sect_per_cl_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fat12cw_pkg::CFG_RESERVED:    reserved_q    <= cfg_data;
				fat12cw_pkg::CFG_TABLE_SECT:  table_sect_q  <= cfg_data;
				fat12cw_pkg::CFG_COPIES:      copies_q      <= cfg_data[2:0];
				fat12cw_pkg::CFG_ROOT_ENTRY:  root_entry_q  <= cfg_data;
				fat12cw_pkg::CFG_SECT_LOG2:   sect_log2_q   <= cfg_data[3:0];
				fat12cw_pkg::CFG_SECT_PER_CL: sect_per_cl_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		root_end_q <= fat12cw_pkg::root_end(reserved_q, table_sect_q, copies_q,
			root_entry_q, sect_log2_q);
	end

	always_comb begin
		step_now = ((opcode == fat12cw_pkg::OP_START) &&
			(start_cluster >= fat12cw_pkg::FIRST_CLUSTER)) ||
			((opcode == fat12cw_pkg::OP_ADVANCE) && chain_active_q);
		cl_now    = (opcode == fat12cw_pkg::OP_START) ? start_cluster : current_cluster_q;
		idx_now   = fat12cw_pkg::entry_addr(cl_now);
		odd_addr  = idx_now[12:1];
		even_addr = idx_now[0] ? AW'(idx_now[12:1] + 12'd1) : idx_now[12:1];
		unique case (opcode)
			fat12cw_pkg::OP_START: begin
				status_now = (start_cluster < fat12cw_pkg::FIRST_CLUSTER) ?
					fat12cw_pkg::ST_BAD_START : fat12cw_pkg::ST_OK;
			end
			fat12cw_pkg::OP_ADVANCE: begin
				status_now = chain_active_q ? fat12cw_pkg::ST_OK : fat12cw_pkg::ST_NO_CHAIN;
			end
			default: status_now = fat12cw_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && (opcode == fat12cw_pkg::OP_WRITE) && !table_byte_addr[0]) begin
			mem_even[table_byte_addr[12:1]] <= table_byte;
		end
		if (acc && step_now) begin
			rd_even_s1 <= mem_even[even_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (opcode == fat12cw_pkg::OP_WRITE) && table_byte_addr[0]) begin
			mem_odd[table_byte_addr[12:1]] <= table_byte;
		end
		if (acc && step_now) begin
			rd_odd_s1 <= mem_odd[odd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			step_s1  <= 1'b0;
		end else begin
			valid_s1 <= acc;
			step_s1  <= acc && step_now;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_now;
			cl_s1     <= cl_now;
			swap_s1   <= idx_now[0];
		end
	end

	always_comb begin
		word   = swap_s1 ? {rd_even_s1, rd_odd_s1} : {rd_odd_s1, rd_even_s1};
		nxt    = cl_s1[0] ? word[15:4] : word[11:0];
		is_end = nxt >= fat12cw_pkg::END_MARK;
		sector = root_end_q + 24'(({12'b0, cl_s1} - 24'd2) * {16'b0, sect_per_cl_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_cluster_q <= 12'd0;
			chain_active_q    <= 1'b0;
		end else if (step_s1) begin
			current_cluster_q <= nxt;
			if (is_end) begin
				chain_active_q <= 1'b0;
			end
		end else if (acc && (opcode == fat12cw_pkg::OP_START)) begin
			chain_active_q <= step_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q  <= status_s1;
			cluster_q <= step_s1 ? cl_s1 : 12'd0;
			sector_q  <= step_s1 ? sector : 24'd0;
			next_q    <= step_s1 ? nxt : 12'd0;
			end_q     <= step_s1 && is_end;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign cluster      = cluster_q;
	assign sector_addr  = sector_q;
	assign next_cluster = next_q;
	assign chain_end    = end_q;

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !step_now |=> ##1 done)
		else $error("A one-cycle command did not produce its result.");

	a_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		acc && step_now |=> busy ##1 done)
		else $error("A chain step did not produce its result two cycles later.");

	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("Busy stayed high for more than one cycle.");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done && chain_end |-> !chain_active_q)
		else $error("The chain stayed active after its last cluster.");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for fat12_cluster_chain_walker_core: table loads, chain starts and
// advances under several register settings; each result beat is checked against a directed
// row's expected value or an in-bench model. Depends on fat12cw_pkg and the core only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fat12cw_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] cluster;
		logic [23:0] sector;
		logic [11:0] next;
		logic        chain_end;
	} walk_result_t;

	typedef struct packed {
		logic [1:0]   op;
		logic [12:0]  addr;
		logic [7:0]   data;
		logic [11:0]  sc;
		logic         typed;
		walk_result_t want;
	} walk_row_t;

	localparam walk_result_t RES_CLEAR     = '0;
	localparam walk_result_t RES_NO_CHAIN  = {ST_NO_CHAIN, 49'd0};
	localparam walk_result_t RES_BAD_START = {ST_BAD_START, 49'd0};

	localparam walk_row_t DIRECTED [22] = '{
		'{OP_ADVANCE, 13'd0,    8'h00, 12'd0,    1'b1, RES_NO_CHAIN},
		'{OP_START,   13'd0,    8'h00, 12'd0,    1'b1, RES_BAD_START},
		'{OP_START,   13'd8191, 8'hFF, 12'd1,    1'b1, RES_BAD_START},
		'{OP_NOP,     13'd8191, 8'hFF, 12'd4095, 1'b1, RES_CLEAR},
		'{OP_WRITE,   13'd0,    8'hFF, 12'd4095, 1'b1, RES_CLEAR},
		'{OP_WRITE,   13'd8191, 8'h00, 12'd0,    1'b1, RES_CLEAR},
		'{OP_WRITE,   13'd3,    8'h03, 12'd0,    1'b1, RES_CLEAR},
		'{OP_WRITE,   13'd4,    8'hF0, 12'd0,    1'b1, RES_CLEAR},
		'{OP_WRITE,   13'd5,    8'hFF, 12'd0,    1'b1, RES_CLEAR},
		'{OP_START,   13'd0,    8'h00, 12'd2,    1'b0, RES_CLEAR},
		'{OP_ADVANCE, 13'd0,    8'h00, 12'd0,    1'b0, RES_CLEAR},
		'{OP_ADVANCE, 13'd0,    8'h00, 12'd0,    1'b1, RES_NO_CHAIN},
		'{OP_WRITE,   13'd6142, 8'h80, 12'd0,    1'b1, RES_CLEAR},
		'{OP_WRITE,   13'd6143, 8'hFF, 12'd0,    1'b1, RES_CLEAR},
		'{OP_START,   13'd0,    8'h00, 12'd4095, 1'b0, RES_CLEAR},
		'{OP_WRITE,   13'd1,    8'hFF, 12'd0,    1'b1, RES_CLEAR},
		'{OP_WRITE,   13'd2,    8'hFF, 12'd0,    1'b1, RES_CLEAR},
		'{OP_WRITE,   13'd9,    8'h01, 12'd0,    1'b1, RES_CLEAR},
		'{OP_WRITE,   13'd10,   8'h00, 12'd0,    1'b1, RES_CLEAR},
		'{OP_START,   13'd0,    8'h00, 12'd6,    1'b0, RES_CLEAR},
		'{OP_ADVANCE, 13'd0,    8'h00, 12'd0,    1'b0, RES_CLEAR},
		'{OP_ADVANCE, 13'd0,    8'h00, 12'd0,    1'b1, RES_NO_CHAIN}
	};

	localparam logic [2:0] REG_ORDER [6] = '{CFG_RESERVED, CFG_TABLE_SECT, CFG_COPIES,
		CFG_ROOT_ENTRY, CFG_SECT_LOG2, CFG_SECT_PER_CL};
	localparam logic [15:0] PLAN_MIN  [6] = '{16'd0, 16'd1, 16'd1, 16'd0, 16'd9, 16'd1};
	localparam logic [15:0] PLAN_MAX  [6] = '{16'hFFFF, 16'hFFFF, 16'd4, 16'hFFFF, 16'd12, 16'd128};
	localparam logic [15:0] PLAN_WIDE [6] = '{16'hFFFF, 16'd0, 16'd7, 16'hFFFF, 16'd15, 16'd255};
	localparam logic [15:0] PLAN_ZERO [6] = '{16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd0};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [12:0] table_byte_addr;
	logic [7:0]  table_byte;
	logic [11:0] start_cluster;
	logic        done;
	logic [1:0]  status;
	logic [11:0] cluster;
	logic [23:0] sector_addr;
	logic [11:0] next_cluster;
	logic        chain_end;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	logic [15:0] reg_reserved;
	logic [15:0] reg_spt;
	logic [2:0]  reg_copies;
	logic [15:0] reg_root;
	logic [3:0]  reg_log2;
	logic [7:0]  reg_spc;
	logic [7:0]  fat_image [TABLE_BYTES];
	bit          fat_written [TABLE_BYTES];
	logic [11:0] cur_cluster;
	bit          walking;

	walk_result_t pending_results [$];
	int unsigned  mismatches;
	int unsigned  sent;
	int unsigned  burst_left;

	fat12_cluster_chain_walker_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.table_byte_addr (table_byte_addr),
		.table_byte      (table_byte),
		.start_cluster   (start_cluster),
		.done            (done),
		.status          (status),
		.cluster         (cluster),
		.sector_addr     (sector_addr),
		.next_cluster    (next_cluster),
		.chain_end       (chain_end),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [11:0] fat_entry(input logic [11:0] cl);
		int unsigned idx;
		logic [15:0] word;
		idx = (int'(cl) * 3) >> 1;
		word = {fat_image[idx + 1], fat_image[idx]};
		return cl[0] ? word[15:4] : word[11:0];
	endfunction

	function automatic logic [23:0] first_sector(input logic [11:0] cl);
		logic [31:0] dir_bytes;
		logic [31:0] dir_sectors;
		logic [31:0] base;
		dir_bytes = {11'd0, reg_root, 5'd0};
		dir_sectors = (dir_bytes + ((32'd1 << reg_log2) - 32'd1)) >> reg_log2;
		base = 32'(reg_reserved) + 32'(reg_copies) * 32'(reg_spt) + dir_sectors;
		return 24'(base + (32'(cl) - 32'(FIRST_CLUSTER)) * 32'(reg_spc));
	endfunction

	function automatic walk_result_t follow_link();
		walk_result_t r;
		r = '0;
		r.cluster = cur_cluster;
		r.next = fat_entry(cur_cluster);
		r.sector = first_sector(cur_cluster);
		r.chain_end = r.next >= END_MARK;
		cur_cluster = r.next;
		if (r.chain_end) walking = 1'b0;
		return r;
	endfunction

	function automatic walk_result_t walk_predict(input logic [1:0] op, input logic [12:0] addr,
		input logic [7:0] data, input logic [11:0] sc);
		walk_result_t r;
		r = '0;
		case (op)
			OP_WRITE: begin
				fat_image[addr] = data;
				fat_written[addr] = 1'b1;
			end
			OP_START: begin
				if (sc < FIRST_CLUSTER) begin
					walking = 1'b0;
					r.status = ST_BAD_START;
				end else begin
					cur_cluster = sc;
					walking = 1'b1;
					r = follow_link();
				end
			end
			OP_ADVANCE: begin
				if (!walking) r.status = ST_NO_CHAIN;
				else r = follow_link();
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic string fmt(input walk_result_t r);
		return $sformatf("status %0d cluster %03h sector %06h next %03h end %0b",
			r.status, r.cluster, r.sector, r.next, r.chain_end);
	endfunction

	function automatic logic [15:0] plan_value(input int p, input int r);
		case (p)
			1: return PLAN_MIN[r];
			2: return PLAN_MAX[r];
			3: return PLAN_WIDE[r];
			4: return PLAN_ZERO[r];
			5: return 16'($urandom);
			default: begin
				case (REG_ORDER[r])
					CFG_TABLE_SECT:  return 16'($urandom_range(1, 65535));
					CFG_COPIES:      return 16'($urandom_range(1, 4));
					CFG_ROOT_ENTRY:  return 16'($urandom_range(0, 1024));
					CFG_SECT_LOG2:   return 16'($urandom_range(9, 12));
					CFG_SECT_PER_CL: return 16'($urandom_range(1, 128));
					default:         return 16'($urandom);
				endcase
			end
		endcase
	endfunction

	task automatic send_cmd(input logic [1:0] op, input logic [12:0] addr, input logic [7:0] data,
		input logic [11:0] sc, input bit typed = 1'b0, input walk_result_t want = '0);
		walk_result_t r;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		table_byte_addr <= addr;
		table_byte <= data;
		start_cluster <= sc;
		do @(posedge clk); while (busy);
		r = walk_predict(op, addr, data, sc);
		pending_results.push_back(typed ? want : r);
		sent++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RESERVED:    reg_reserved = val;
			CFG_TABLE_SECT:  reg_spt = val;
			CFG_COPIES:      reg_copies = val[2:0];
			CFG_ROOT_ENTRY:  reg_root = val;
			CFG_SECT_LOG2:   reg_log2 = val[3:0];
			CFG_SECT_PER_CL: reg_spc = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes any byte of the cluster's entry that was never loaded, so no walk reads
	// undefined table contents.
	task automatic cover_entry(input logic [11:0] c);
		int unsigned idx;
		idx = (int'(c) * 3) >> 1;
		for (int k = 0; k < 2; k++) begin
			if (!fat_written[idx + k])
				send_cmd(OP_WRITE, 13'(idx + k), 8'($urandom), 12'($urandom));
		end
	endtask

	task automatic put_entry(input logic [11:0] c, input logic [11:0] e);
		int unsigned idx;
		logic [7:0] lo;
		logic [7:0] hi;
		idx = (int'(c) * 3) >> 1;
		lo = fat_written[idx] ? fat_image[idx] : 8'($urandom);
		hi = fat_written[idx + 1] ? fat_image[idx + 1] : 8'($urandom);
		if (c[0]) begin
			lo[7:4] = e[3:0];
			hi = e[11:4];
		end else begin
			lo = e[7:0];
			hi[3:0] = e[11:8];
		end
		send_cmd(OP_WRITE, 13'(idx), lo, 12'($urandom));
		send_cmd(OP_WRITE, 13'(idx + 1), hi, 12'($urandom));
	endtask

	task automatic start_at(input logic [11:0] c);
		if (c >= FIRST_CLUSTER) cover_entry(c);
		send_cmd(OP_START, 13'($urandom), 8'($urandom), c);
	endtask

	task automatic step_chain();
		if (walking) cover_entry(cur_cluster);
		send_cmd(OP_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom));
	endtask

	task automatic walk_chain();
		logic [11:0] links [$];
		logic [11:0] tail;
		int unsigned len;
		int unsigned roll;
		len = $urandom_range(1, 6);
		repeat (len) begin
			if ($urandom_range(0, 2) == 0) links.push_back(12'($urandom_range(2, 47)));
			else links.push_back(12'($urandom_range(2, 4095)));
		end
		roll = $urandom_range(0, 15);
		if (roll < 12) tail = END_MARK + 12'($urandom_range(0, 7));
		else if (roll < 14) tail = 12'($urandom_range(0, 1));
		else tail = 12'($urandom);
		for (int i = 0; i < len; i++)
			put_entry(links[i], (i == len - 1) ? tail : links[i + 1]);
		start_at(links[0]);
		repeat (len + $urandom_range(0, 2)) step_chain();
	endtask

	task automatic noise_item();
		case ($urandom_range(0, 4))
			0: send_cmd(OP_NOP, 13'($urandom), 8'($urandom), 12'($urandom));
			1: send_cmd(OP_WRITE, 13'($urandom), 8'($urandom), 12'($urandom));
			2: start_at(12'($urandom_range(0, 1)));
			3: step_chain();
			default: start_at(12'($urandom));
		endcase
	endtask

	always @(posedge clk) begin
		walk_result_t got;
		walk_result_t want;
		if (arst_n && done) begin
			got = {status, cluster, sector_addr, next_cluster, chain_end};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat: %s", fmt(got));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.cluster !== want.cluster ||
					got.sector !== want.sector || got.next !== want.next ||
					got.chain_end !== want.chain_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %s, got %s", fmt(want), fmt(got));
				end
			end
		end
	end

	initial begin
		int unsigned phase_base;
		int unsigned drain_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_NOP;
		table_byte_addr = '0;
		table_byte = '0;
		start_cluster = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_RESERVED;
		cfg_data = '0;
		reg_reserved = 16'd1;
		reg_spt = 16'd9;
		reg_copies = 3'd2;
		reg_root = 16'd224;
		reg_log2 = 4'd9;
		reg_spc = 8'd1;
		cur_cluster = '0;
		walking = 1'b0;
		mismatches = 0;
		sent = 0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_cmd(DIRECTED[i].op, DIRECTED[i].addr, DIRECTED[i].data, DIRECTED[i].sc,
				DIRECTED[i].typed, DIRECTED[i].want);

		for (int p = 0; p <= 6; p++) begin
			if (p != 0) begin
				settle();
				for (int r = 0; r < 6; r++) write_reg(REG_ORDER[r], plan_value(p, r));
			end
			phase_base = sent;
			while (sent - phase_base < 75) begin
				if ($urandom_range(0, 9) < 7) walk_chain();
				else noise_item();
			end
		end

		@(negedge clk);
		start <= 1'b0;
		drain_cycles = 0;
		while (pending_results.size() != 0 && drain_cycles < 10000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### fat12_cluster_chain_walker_core.f
rtl/core/fat12cw_pkg.sv
rtl/core/fat12_cluster_chain_walker_core.sv
tb/sv/tb_top.sv
